// ===== design/com_pkg.sv =====
// shared types and constants for the channel occupancy monitor
package com_pkg;

  localparam int MANU_SLOTS_DEF = 1024;
  localparam int HIT_BITS_DEF   = 24;
  localparam int ID_W           = 24;
  localparam int SLOT_W         = 10;
  localparam int PADS_W         = 8;
  localparam int CFG_W          = 16;
  localparam int EVT_W          = 32;
  localparam int OCC_W          = 16;
  localparam int OUT_HIT_W      = 24;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_DIGIT = 3'd1;
  localparam logic [2:0] OP_EOE   = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_RESET = 3'd4;

  localparam logic CFG_EPW = 1'b0;
  localparam logic CFG_THR = 1'b1;

  localparam logic [CFG_W-1:0] EPW_RESET = 16'd100;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // latch input beat
    logic scan_clr;   // reset scan pointer
    logic scan_step;  // compare one table entry, advance pointer
    logic digit_inc;  // read-modify-write live hit of found slot
    logic load_wr;    // write map entry
    logic evt_inc;    // bump event count
    logic evt_clr;    // zero event count
    logic copy_step;  // copy/clear one slot of the window sweep
    logic clr_step;   // zero one slot of map, live and snapshot tables after reset
    logic div_start;  // start the occupancy divider
    logic rd_issue;   // issue memory read of read slot or found slot
    logic out_load;   // load result register
  } com_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic div_busy;
    logic win_close;
    logic slot_ok;
    logic mod_busy;
  } com_sts_t;

endpackage

// ===== design/com_ram.sv =====
// generic simple dual port ram (one write port, one read port) with registered read
module com_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/com_div.sv =====
// restoring divider for occupancy, one quotient bit per cycle
module com_div import com_pkg::*; #(
  parameter int HIT_BITS = HIT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [HIT_BITS-1:0] hits,
  input  logic [CFG_W-1:0]    epw,
  input  logic [PADS_W-1:0]   pads,
  output logic                busy,
  output logic [OCC_W-1:0]    occ
);

  localparam int NUM_W = HIT_BITS + OCC_W;
  localparam int DEN_W = CFG_W + PADS_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             pz;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem[DEN_W-1:0], num[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      num  <= {hits, {OCC_W{1'b0}}};
      den  <= (epw == '0 ? CFG_W'(1) : epw) * pads;
      rem  <= '0;
      quo  <= '0;
      pz   <= (pads == '0);
    end else if (busy) begin
      rem  <= ge ? rem_sh - {1'b0, den} : rem_sh;
      quo  <= {quo[NUM_W-2:0], ge};
      num  <= {num[NUM_W-2:0], 1'b0};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // saturate to q0.16
  assign occ = (pz || (quo > NUM_W'({OCC_W{1'b1}}))) ? {OCC_W{1'b1}} : quo[OCC_W-1:0];

endmodule

// ===== design/com_dp.sv =====
// datapath: map table, hit counters, event count, result register
module com_dp import com_pkg::*; #(
  parameter int MANU_SLOTS = MANU_SLOTS_DEF,
  parameter int HIT_BITS   = HIT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  com_cmd_t           cmd,
  output com_sts_t           sts,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_idx,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [2:0]         op,
  input  logic [ID_W-1:0]    abs_id,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [PADS_W-1:0]  pads,
  output logic [SLOT_W-1:0]  slot_out,
  output logic               matched,
  output logic [OUT_HIT_W-1:0] window_hits,
  output logic [PADS_W-1:0]  pads_out,
  output logic [OCC_W-1:0]   occupancy_q16,
  output logic               over_threshold,
  output logic               window_done,
  output logic [EVT_W-1:0]   events_seen
);

  localparam int AW = (MANU_SLOTS > 1) ? $clog2(MANU_SLOTS) : 1;
  localparam int PW = AW + 1;
  localparam int MW = $clog2(EVT_W + 1);

  logic [CFG_W-1:0]    epw;
  logic [CFG_W-1:0]    thr;
  logic [2:0]          op_r;
  logic [ID_W-1:0]     id_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PADS_W-1:0]   pads_r;
  logic [EVT_W-1:0]    evt;
  logic [EVT_W-1:0]    evt_next;
  logic                win_close;
  logic [CFG_W-1:0]    wcnt;
  logic [CFG_W-1:0]    wlen;
  logic [PW-1:0]       ptr;
  logic [AW-1:0]       ptr_d;
  logic                ptr_d_v;
  logic [AW-1:0]       hit_idx;
  logic                found;
  logic                slot_ok;
  logic [AW-1:0]       slot_a;

  logic                mod_busy;
  logic [MW-1:0]       mod_cnt;
  logic [EVT_W-1:0]    mod_num;
  logic [CFG_W:0]      mod_rem;
  logic [CFG_W:0]      mod_sh;
  logic                mod_ge;
  logic [CFG_W:0]      mod_nx;

  logic [ID_W:0]       id_rd;
  logic [PADS_W-1:0]   pad_rd;
  logic [HIT_BITS-1:0] live_rd;
  logic [HIT_BITS-1:0] snap_rd;
  logic [AW-1:0]       id_ra;
  logic [AW-1:0]       live_ra;
  logic                live_we;
  logic [AW-1:0]       live_wa;
  logic [HIT_BITS-1:0] live_wd;
  logic                snap_we;
  logic [AW-1:0]       snap_wa;
  logic [HIT_BITS-1:0] snap_wd;
  logic                ids_we;
  logic [AW-1:0]       ids_wa;
  logic [ID_W:0]       ids_wd;
  logic                clr_we;
  logic [AW-1:0]       copy_a;
  logic                copy_v;
  logic                div_busy;
  logic [OCC_W-1:0]    occ;

  function automatic logic win_close_sweep();
    return (op_r == OP_EOE) || (op_r == OP_RESET);
  endfunction

  assign wlen    = (epw == '0) ? CFG_W'(1) : epw;
  assign slot_ok = ({{(PW > SLOT_W ? PW-SLOT_W : 0){1'b0}}, slot_r} < (PW > SLOT_W ? PW : SLOT_W)'(MANU_SLOTS));
  assign slot_a  = AW'(slot_r);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      epw <= EPW_RESET;
      thr <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_EPW: epw <= cfg_data;
        CFG_THR: thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      op_r <= OP_LOAD;
    end else if (cmd.capture) begin
      op_r   <= op;
      id_r   <= abs_id;
      slot_r <= slot;
      pads_r <= pads;
    end
  end

  // window phase is event count modulo window length, rebuilt bit by bit on a length write
  assign mod_sh = {mod_rem[CFG_W-1:0], mod_num[EVT_W-1]};
  assign mod_ge = (mod_sh >= {1'b0, wlen});
  assign mod_nx = mod_ge ? mod_sh - {1'b0, wlen} : mod_sh;

  // event counter with window phase counter, count wrap lands on a window boundary
  assign evt_next  = evt + 1'b1;
  assign win_close = (op_r == OP_RESET) || (wcnt + 1'b1 >= wlen) || (evt_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      evt      <= '0;
      wcnt     <= '0;
      mod_busy <= 1'b0;
    end else if (cfg_we && cfg_idx == CFG_EPW) begin
      mod_busy <= 1'b1;
      mod_cnt  <= MW'(EVT_W);
      mod_num  <= evt;
      mod_rem  <= '0;
    end else if (mod_busy) begin
      mod_rem <= mod_nx;
      mod_num <= {mod_num[EVT_W-2:0], 1'b0};
      mod_cnt <= mod_cnt - 1'b1;
      if (mod_cnt == MW'(1)) begin
        mod_busy <= 1'b0;
        wcnt     <= mod_nx[CFG_W-1:0];
      end
    end else if (cmd.evt_clr) begin
      evt  <= '0;
      wcnt <= '0;
    end else if (cmd.evt_inc) begin
      evt  <= evt_next;
      wcnt <= win_close ? '0 : wcnt + 1'b1;
    end
  end

  // scan pointer used by id search, window sweep and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      ptr_d_v <= 1'b0;
    end else if (cmd.scan_clr) begin
      ptr     <= '0;
      ptr_d_v <= 1'b0;
    end else if (cmd.scan_step || cmd.copy_step || cmd.clr_step) begin
      ptr_d_v <= (ptr < PW'(MANU_SLOTS));
      ptr_d   <= AW'(ptr);
      if (ptr < PW'(MANU_SLOTS)) begin
        ptr <= ptr + 1'b1;
      end
    end else begin
      ptr_d_v <= 1'b0;
    end
  end
  assign sts.scan_last = (ptr == PW'(MANU_SLOTS)) && !ptr_d_v;

  // compare one entry per cycle, later match wins
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      found   <= 1'b0;
      hit_idx <= '0;
    end else if (ptr_d_v && !win_close_sweep() && id_rd[ID_W] &&
                 id_rd[ID_W-1:0] == id_r) begin
      found   <= 1'b1;
      hit_idx <= ptr_d;
    end
  end

  // memory addressing
  assign clr_we  = cmd.clr_step && (ptr < PW'(MANU_SLOTS));
  assign id_ra   = (cmd.rd_issue) ? slot_a : AW'(ptr);
  assign live_ra = cmd.rd_issue ? hit_idx : AW'(ptr);
  assign copy_v  = ptr_d_v && win_close_sweep();
  assign copy_a  = ptr_d;
  assign snap_we = copy_v || clr_we;
  assign snap_wa = clr_we ? AW'(ptr) : copy_a;
  assign snap_wd = clr_we ? '0 : live_rd;

  // map entry carries its valid bit on top of the id
  assign ids_we = (cmd.load_wr && slot_ok) || clr_we;
  assign ids_wa = clr_we ? AW'(ptr) : slot_a;
  assign ids_wd = clr_we ? '0 : {1'b1, id_r};

  always_comb begin
    live_we = 1'b0;
    live_wa = copy_a;
    live_wd = '0;
    if (clr_we) begin
      live_we = 1'b1;
      live_wa = AW'(ptr);
    end else if (copy_v) begin
      live_we = 1'b1;
    end else if (cmd.digit_inc) begin
      live_we = 1'b1;
      live_wa = hit_idx;
      live_wd = (live_rd == {HIT_BITS{1'b1}}) ? live_rd : live_rd + 1'b1;
    end
  end

  com_ram #(.WIDTH(ID_W + 1), .DEPTH(MANU_SLOTS)) u_ids (
    .clk(clk), .we(ids_we), .waddr(ids_wa), .wdata(ids_wd),
    .raddr(id_ra), .rdata(id_rd));

  com_ram #(.WIDTH(PADS_W), .DEPTH(MANU_SLOTS)) u_pads (
    .clk(clk), .we(cmd.load_wr && slot_ok), .waddr(slot_a), .wdata(pads_r),
    .raddr(slot_a), .rdata(pad_rd));

  com_ram #(.WIDTH(HIT_BITS), .DEPTH(MANU_SLOTS)) u_live (
    .clk(clk), .we(live_we), .waddr(live_wa), .wdata(live_wd),
    .raddr(live_ra), .rdata(live_rd));

  com_ram #(.WIDTH(HIT_BITS), .DEPTH(MANU_SLOTS)) u_snap (
    .clk(clk), .we(snap_we), .waddr(snap_wa), .wdata(snap_wd),
    .raddr(slot_a), .rdata(snap_rd));

  com_div #(.HIT_BITS(HIT_BITS)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .hits(snap_rd), .epw(epw),
    .pads(pad_rd), .busy(div_busy), .occ(occ));

  assign sts.div_busy  = div_busy;
  assign sts.win_close = win_close;
  assign sts.slot_ok   = slot_ok;
  assign sts.mod_busy  = mod_busy;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      slot_out       <= '0;
      matched        <= 1'b0;
      window_hits    <= '0;
      pads_out       <= '0;
      occupancy_q16  <= '0;
      over_threshold <= 1'b0;
      window_done    <= 1'b0;
      events_seen    <= evt;
      case (op_r)
        OP_LOAD: slot_out <= slot_r;
        OP_DIGIT: begin
          slot_out <= SLOT_W'(hit_idx);
          matched  <= found;
        end
        OP_EOE: window_done <= (wcnt == '0);
        OP_READ: begin
          slot_out <= slot_r;
          if (slot_ok) begin
            window_hits    <= OUT_HIT_W'(snap_rd);
            pads_out       <= pad_rd;
            occupancy_q16  <= occ;
            over_threshold <= occ > thr;
          end
        end
        OP_RESET: window_done <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/com_ctrl.sv =====
// controller state machine sequencing each beat
module com_ctrl import com_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  output logic       out_valid,
  input  logic       out_stall,
  input  com_sts_t   sts,
  output com_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_INC   = 4'd4;
  localparam logic [3:0] S_SWEEP = 4'd5;
  localparam logic [3:0] S_RREAD = 4'd6;
  localparam logic [3:0] S_DIVGO = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_HOLD  = 4'd10;
  localparam logic [3:0] S_CLR   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] op_r;
  logic       sweep;

  assign in_stall = (state != S_IDLE) || sts.mod_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      op_r  <= OP_LOAD;
      sweep <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && !in_stall) begin
        op_r <= op;
      end
      if (state == S_DEC) begin
        sweep <= (op_r == OP_RESET) || (op_r == OP_EOE && sts.win_close);
      end
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    out_valid  = (state == S_HOLD);
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: if (in_valid && !sts.mod_busy) begin
        cmd.capture = 1'b1;
        state_next  = S_DEC;
      end
      S_DEC: begin
        cmd.scan_clr = 1'b1;
        case (op_r)
          OP_LOAD: begin
            cmd.load_wr = 1'b1;
            state_next  = S_OUT;
          end
          OP_DIGIT: state_next = S_SCAN;
          OP_EOE: begin
            cmd.evt_inc = 1'b1;
            state_next  = sts.win_close ? S_SWEEP : S_OUT;
          end
          OP_RESET: begin
            cmd.evt_clr = 1'b1;
            state_next  = S_SWEEP;
          end
          OP_READ: state_next = S_RREAD;
          default: state_next = S_OUT;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_INC;
      end
      S_INC: begin
        cmd.digit_inc = 1'b1;
        state_next    = S_OUT;
      end
      S_SWEEP: begin
        cmd.copy_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_OUT;
        end
      end
      S_RREAD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: if (!sts.div_busy) begin
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = S_HOLD;
      end
      S_HOLD: if (!out_stall) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a result only leaves from the hold state
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_HOLD) else $error("result outside hold");
  // no beat taken while an item is in work
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  // sweep only on a window close or a reset item
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> sweep || $past(state) == S_DEC) else $error("bad sweep");

endmodule

// ===== design/channel_occupancy_monitor.sv =====
// channel occupancy monitor top level
// load writes the map entry; digit scans the map (one table entry compared per cycle), then
// bumps the live hit count at the match index; end of event bumps the event count and on a
// window close, like a reset item, sweeps live into snapshot (one slot per cycle); read runs
// the bit-serial occupancy divider; one item at a time; a window length write stalls input
// reset: synchronous, then a clearing pass of map, live and snapshot tables
module channel_occupancy_monitor import com_pkg::*; #(
  parameter int MANU_SLOTS = MANU_SLOTS_DEF,
  parameter int HIT_BITS   = HIT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           op,
  input  logic [ID_W-1:0]      abs_id,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [PADS_W-1:0]    pads,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    slot_out,
  output logic                 matched,
  output logic [OUT_HIT_W-1:0] window_hits,
  output logic [PADS_W-1:0]    pads_out,
  output logic [OCC_W-1:0]     occupancy_q16,
  output logic                 over_threshold,
  output logic                 window_done,
  output logic [EVT_W-1:0]     events_seen
);

  com_cmd_t cmd;
  com_sts_t sts;

  com_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  com_dp #(.MANU_SLOTS(MANU_SLOTS), .HIT_BITS(HIT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .op(op), .abs_id(abs_id), .slot(slot), .pads(pads),
    .slot_out(slot_out), .matched(matched), .window_hits(window_hits),
    .pads_out(pads_out), .occupancy_q16(occupancy_q16),
    .over_threshold(over_threshold), .window_done(window_done),
    .events_seen(events_seen));

endmodule
